// ===== hw/rtl/fan_ctl_pkg.sv =====
// Shared constants for the exhaust fan mode controller: event codes, mode,
// phase, command and drive source codes, register map and reset values.
// No dependencies.
`default_nettype none

package fan_ctl_pkg;

    // Event codes (input operation field)
    localparam logic [2:0] OP_CTRL_TICK    = 3'd0;
    localparam logic [2:0] OP_GAS_TICK     = 3'd1;
    localparam logic [2:0] OP_MODE_KEY     = 3'd2;
    localparam logic [2:0] OP_SPEED_KEY    = 3'd3;
    localparam logic [2:0] OP_MOTOR_TOGGLE = 3'd4;

    // Operating modes
    localparam logic [1:0] FAN_STANDBY = 2'd0;
    localparam logic [1:0] FAN_MANUAL  = 2'd1;
    localparam logic [1:0] FAN_AUTO    = 2'd2;
    localparam logic [1:0] FAN_ANTIBF  = 2'd3;

    // Auto mode phases
    localparam logic [1:0] PH_STARTUP = 2'd0;
    localparam logic [1:0] PH_COOKING = 2'd1;
    localparam logic [1:0] PH_DELAY   = 2'd2;

    // Motor commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Drive sources
    localparam logic [1:0] SRC_HOLD = 2'd0;
    localparam logic [1:0] SRC_MIN  = 2'd1;
    localparam logic [1:0] SRC_PID  = 2'd2;
    localparam logic [1:0] SRC_WIND = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_STARTUP_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_COOKING_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_DELAY_OFF       = 3'd2;
    localparam logic [2:0] REG_GAS_NORMAL      = 3'd3;
    localparam logic [2:0] REG_GAS_HIGH        = 3'd4;

    localparam int unsigned ADDR_W = 5;

    localparam logic [15:0] RST_STARTUP_TIMEOUT = 16'd60000;
    localparam logic [15:0] RST_COOKING_TIMEOUT = 16'd60000;
    localparam logic [15:0] RST_DELAY_OFF       = 16'd10000;
    localparam logic [15:0] RST_GAS_NORMAL      = 16'd100;
    localparam logic [15:0] RST_GAS_HIGH        = 16'd300;

    // Counter step per control tick, in ms
    localparam logic [15:0] TICK_MS = 16'd50;

endpackage : fan_ctl_pkg

`default_nettype wire

// ===== hw/rtl/fan_mode_and_auto_timeout_controller_unit.sv =====
// Top level of the exhaust fan mode controller: APB register file, input
// register, single-pass event update and result register.
// Depends on fan_ctl_pkg.
`default_nettype none

// Takes one event per request (control tick, gas tick, mode key, speed key,
// motor toggle) on the slave stream and answers each with exactly one result
// on the master stream. A request is registered, then processed against the
// controller state combinationally and written to the result register, and a
// new request is taken every cycle as long as the result side keeps up. The
// event code travels in s_axis_tuser. Timeouts and gas thresholds sit in five
// 16-bit registers at byte addresses 0x00..0x10; write them only while no
// request is in flight.
module fan_mode_and_auto_timeout_controller_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [0] cooking_active, [16:1] gas_level
    input  wire logic [2:0]  s_axis_tuser,  // [2:0] operation
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [1:0] mode, [3:2] auto_phase,
                                            // [4] motor_on, [6:5] motor_cmd,
                                            // [8:7] drive_source, [9] level_high,
                                            // [10] gas_fan_active
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fan_ctl_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import fan_ctl_pkg::*;

    // configuration registers
    logic [15:0] startup_timeout_reg;
    logic [15:0] cooking_timeout_reg;
    logic [15:0] delay_off_reg;
    logic [15:0] gas_normal_reg;
    logic [15:0] gas_high_reg;

    logic [2:0]  reg_index;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            startup_timeout_reg <= RST_STARTUP_TIMEOUT;
            cooking_timeout_reg <= RST_COOKING_TIMEOUT;
            delay_off_reg       <= RST_DELAY_OFF;
            gas_normal_reg      <= RST_GAS_NORMAL;
            gas_high_reg        <= RST_GAS_HIGH;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_STARTUP_TIMEOUT: startup_timeout_reg <= pwdata[15:0];
                REG_COOKING_TIMEOUT: cooking_timeout_reg <= pwdata[15:0];
                REG_DELAY_OFF:       delay_off_reg       <= pwdata[15:0];
                REG_GAS_NORMAL:      gas_normal_reg      <= pwdata[15:0];
                REG_GAS_HIGH:        gas_high_reg        <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_STARTUP_TIMEOUT: prdata = {16'd0, startup_timeout_reg};
            REG_COOKING_TIMEOUT: prdata = {16'd0, cooking_timeout_reg};
            REG_DELAY_OFF:       prdata = {16'd0, delay_off_reg};
            REG_GAS_NORMAL:      prdata = {16'd0, gas_normal_reg};
            REG_GAS_HIGH:        prdata = {16'd0, gas_high_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // pipeline control
    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic        cooking_reg;
    logic [15:0] gas_reg;
    logic        out_valid_reg;
    logic        advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg      <= s_axis_tuser;
            cooking_reg <= s_axis_tdata[0];
            gas_reg     <= s_axis_tdata[16:1];
        end
    end

    // controller state
    logic [1:0]  mode_reg,        mode_next;
    logic [1:0]  phase_reg,       phase_next;
    logic        running_reg,     running_next;
    logic        gas_active_reg,  gas_active_next;
    logic        use_high_reg,    use_high_next;
    logic        level_reg,       level_next;
    logic [15:0] startup_ms_reg,  startup_ms_next;
    logic [15:0] cooking_ms_reg,  cooking_ms_next;
    logic [1:0]  cmd_next;
    logic [1:0]  src_next;

    logic [16:0] startup_sum;
    logic [16:0] cooking_sum;
    logic [15:0] startup_sat;
    logic [15:0] cooking_sat;
    logic [15:0] gas_thr;

    assign startup_sum = {1'b0, startup_ms_reg} + {1'b0, TICK_MS};
    assign cooking_sum = {1'b0, cooking_ms_reg} + {1'b0, TICK_MS};
    assign startup_sat = startup_sum[16] ? 16'hFFFF : startup_sum[15:0];
    assign cooking_sat = cooking_sum[16] ? 16'hFFFF : cooking_sum[15:0];
    assign gas_thr     = use_high_reg ? gas_high_reg : gas_normal_reg;

    always_comb
    begin
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        running_next    = running_reg;
        gas_active_next = gas_active_reg;
        use_high_next   = use_high_reg;
        level_next      = level_reg;
        startup_ms_next = startup_ms_reg;
        cooking_ms_next = cooking_ms_reg;
        cmd_next        = CMD_NONE;
        src_next        = SRC_HOLD;

        unique case (op_reg)
            OP_CTRL_TICK:
            begin
                unique case (mode_reg)
                    FAN_STANDBY:
                    begin
                        cmd_next        = CMD_STOP;
                        running_next    = 1'b0;
                        startup_ms_next = 16'd0;
                        cooking_ms_next = 16'd0;
                        phase_next      = PH_STARTUP;
                    end
                    FAN_MANUAL:
                    begin
                        if (!running_reg)
                        begin
                            cmd_next     = CMD_START;
                            running_next = 1'b1;
                        end
                        src_next = SRC_PID;
                    end
                    FAN_AUTO:
                    begin
                        if (phase_reg == PH_STARTUP)
                        begin
                            if (!running_reg)
                            begin
                                cmd_next     = CMD_START;
                                running_next = 1'b1;
                            end
                            src_next        = SRC_MIN;
                            startup_ms_next = startup_sat;
                            if (cooking_reg)
                            begin
                                phase_next = PH_COOKING;
                            end
                            else if (startup_sat >= startup_timeout_reg)
                            begin
                                mode_next    = FAN_STANDBY;
                                running_next = 1'b0;
                                cmd_next     = CMD_STOP;
                            end
                        end
                        else if (phase_reg == PH_COOKING)
                        begin
                            src_next        = SRC_WIND;
                            cooking_ms_next = cooking_sat;
                            if (!cooking_reg)
                            begin
                                phase_next      = PH_DELAY;
                                cooking_ms_next = 16'd0;
                            end
                            else if (cooking_sat >= cooking_timeout_reg)
                            begin
                                mode_next    = FAN_STANDBY;
                                running_next = 1'b0;
                                cmd_next     = CMD_STOP;
                            end
                        end
                        else
                        begin
                            src_next        = SRC_WIND;
                            cooking_ms_next = cooking_sat;
                            if (cooking_reg)
                            begin
                                phase_next      = PH_COOKING;
                                cooking_ms_next = 16'd0;
                            end
                            else if (cooking_sat >= delay_off_reg)
                            begin
                                mode_next    = FAN_STANDBY;
                                running_next = 1'b0;
                                cmd_next     = CMD_STOP;
                            end
                        end
                    end
                    default:
                    begin
                        src_next = (gas_active_reg && running_reg) ? SRC_PID : SRC_HOLD;
                    end
                endcase
            end
            OP_GAS_TICK:
            begin
                if (mode_reg == FAN_ANTIBF)
                begin
                    // hysteresis: engage between the selected and high levels
                    if (gas_reg >= gas_thr)
                    begin
                        if (gas_reg < gas_high_reg)
                        begin
                            gas_active_next = 1'b1;
                            running_next    = 1'b1;
                            use_high_next   = 1'b1;
                            cmd_next        = CMD_START;
                        end
                    end
                    else if (gas_reg < gas_normal_reg)
                    begin
                        gas_active_next = 1'b0;
                        running_next    = 1'b0;
                        use_high_next   = 1'b0;
                        cmd_next        = CMD_STOP;
                    end
                end
                else
                begin
                    gas_active_next = 1'b0;
                    use_high_next   = 1'b0;
                end
            end
            OP_MODE_KEY:
            begin
                if (mode_reg == FAN_MANUAL)
                begin
                    phase_next = PH_STARTUP;
                end
                mode_next = mode_reg + 2'd1;
                if (mode_next != FAN_AUTO)
                begin
                    running_next = 1'b0;
                    cmd_next     = CMD_STOP;
                end
            end
            OP_SPEED_KEY:
            begin
                level_next = !level_reg;
            end
            OP_MOTOR_TOGGLE:
            begin
                if (running_reg)
                begin
                    cmd_next     = CMD_STOP;
                    running_next = 1'b0;
                    mode_next    = FAN_STANDBY;
                end
                else
                begin
                    cmd_next     = CMD_START;
                    running_next = 1'b1;
                    mode_next    = FAN_MANUAL;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= FAN_STANDBY;
            phase_reg      <= PH_STARTUP;
            running_reg    <= 1'b0;
            gas_active_reg <= 1'b0;
            use_high_reg   <= 1'b0;
            level_reg      <= 1'b0;
            startup_ms_reg <= 16'd0;
            cooking_ms_reg <= 16'd0;
        end
        else if (advance)
        begin
            mode_reg       <= mode_next;
            phase_reg      <= phase_next;
            running_reg    <= running_next;
            gas_active_reg <= gas_active_next;
            use_high_reg   <= use_high_next;
            level_reg      <= level_next;
            startup_ms_reg <= startup_ms_next;
            cooking_ms_reg <= cooking_ms_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_axis_tdata <= {5'd0, gas_active_next, level_next, src_next, cmd_next,
                             running_next, phase_next, mode_next};
        end
    end

endmodule : fan_mode_and_auto_timeout_controller_unit

`default_nettype wire
